// ----- hw/rtl/ecal_pkg.sv -----
package ecal_pkg;

    localparam int unsigned NUM_STAGES = 13;

    localparam logic [35:0] SECS_BIAS = 36'd17179948800;
    localparam logic [19:0] CIVIL_BIAS = 20'd520626;
    localparam logic [18:0] WDAY_BIAS = 19'd4;

    localparam logic [29:0] M675 = 30'(((64'd1 << 39) / 675) + 1);
    localparam logic [19:0] M7 = 20'(((64'd1 << 22) / 7) + 1);
    localparam logic [17:0] M3600 = 18'(((64'd1 << 29) / 3600) + 1);
    localparam logic [12:0] M60 = 13'(((64'd1 << 18) / 60) + 1);
    localparam logic [20:0] M146097 = 21'(((64'd1 << 38) / 146097) + 1);
    localparam logic [18:0] M1460 = 19'(((64'd1 << 29) / 1460) + 1);
    localparam logic [18:0] M36524 = 19'(((64'd1 << 34) / 36524) + 1);
    localparam logic [18:0] M365 = 19'(((64'd1 << 27) / 365) + 1);
    localparam logic [9:0] M100 = 10'(((64'd1 << 16) / 100) + 1);
    localparam logic [11:0] M153 = 12'(((64'd1 << 19) / 153) + 1);
    localparam logic [11:0] M5 = 12'(((64'd1 << 14) / 5) + 1);

    typedef struct packed {
        logic [34:0] secs;
        logic [28:0] q;
        logic [6:0]  low7;
        logic [18:0] dayu;
        logic [16:0] rem;
        logic [19:0] z;
        logic [18:0] wsum;
        logic [2:0]  era;
        logic [16:0] w7;
        logic [17:0] doe;
        logic [11:0] r2;
        logic [6:0]  a;
        logic [2:0]  b;
        logic        c;
        logic [17:0] xv;
        logic [8:0]  yoe;
        logic [1:0]  y100;
        logic [8:0]  doy;
        logic [3:0]  mp;
        logic [8:0]  ylo;
        logic        janfeb;
        logic [11:0] year;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day_of_month;
        logic [3:0]  month_index;
        logic [8:0]  years_since_1900;
        logic [2:0]  weekday;
        logic [8:0]  day_of_year;
        logic        out_of_range;
    } pipe_t;

    function automatic pipe_t stage_step(input int unsigned idx, input pipe_t d,
                                         input logic [13:0] first_year,
                                         input logic [13:0] last_year);
        pipe_t       r;
        logic [35:0] u;
        logic [58:0] p0;
        logic [9:0]  rq;
        logic [40:0] pe;
        logic [34:0] ph;
        logic [38:0] pw;
        logic [36:0] pa;
        logic [36:0] pb;
        logic [24:0] pm;
        logic [36:0] py;
        logic [18:0] pc;
        logic [10:0] v5;
        logic [22:0] pmp;
        logic [10:0] v153;
        logic [22:0] pd;
        logic        leap;
        logic        oor;
        r = d;
        case (idx)
            0:
            begin
                u = 36'($signed(d.secs)) + SECS_BIAS;
                r.q = u[35:7];
                r.low7 = u[6:0];
            end
            1:
            begin
                p0 = 59'(d.q) * 59'(M675);
                r.dayu = p0[57:39];
            end
            2:
            begin
                rq = 10'(d.q - 29'(d.dayu * 19'd675));
                r.rem = {rq, d.low7};
                r.z = 20'(d.dayu) + CIVIL_BIAS;
                r.wsum = d.dayu + WDAY_BIAS;
            end
            3:
            begin
                pe = 41'(d.z) * 41'(M146097);
                r.era = pe[40:38];
                ph = 35'(d.rem) * 35'(M3600);
                r.hour = ph[33:29];
                pw = 39'(d.wsum) * 39'(M7);
                r.w7 = pw[38:22];
            end
            4:
            begin
                r.doe = 18'(d.z - 20'(20'(d.era) * 20'd146097));
                r.r2 = 12'(d.rem - 17'(17'(d.hour) * 17'd3600));
                r.weekday = 3'(d.wsum - 19'(19'(d.w7) * 19'd7));
            end
            5:
            begin
                pa = 37'(d.doe) * 37'(M1460);
                r.a = pa[35:29];
                pb = 37'(d.doe) * 37'(M36524);
                r.b = pb[36:34];
                r.c = (d.doe == 18'd146096);
                pm = 25'(d.r2) * 25'(M60);
                r.minute = pm[23:18];
            end
            6:
            begin
                r.xv = d.doe - 18'(d.a) + 18'(d.b) - 18'(d.c);
                r.second = 6'(d.r2 - 12'(12'(d.minute) * 12'd60));
            end
            7:
            begin
                py = 37'(d.xv) * 37'(M365);
                r.yoe = py[35:27];
            end
            8:
            begin
                pc = 19'(d.yoe) * 19'(M100);
                r.y100 = pc[17:16];
            end
            9:
            begin
                r.doy = 9'(d.doe - 18'(18'(d.yoe) * 18'd365)
                        - 18'(d.yoe[8:2]) + 18'(d.y100));
            end
            10:
            begin
                v5 = 11'(11'(d.doy) * 11'd5) + 11'd2;
                pmp = 23'(v5) * 23'(M153);
                r.mp = pmp[22:19];
            end
            11:
            begin
                v153 = 11'(11'(d.mp) * 11'd153) + 11'd2;
                pd = 23'(v153) * 23'(M5);
                r.day_of_month = 5'(d.doy - 9'(pd[22:14]) + 9'd1);
                r.janfeb = (d.mp >= 4'd10);
                r.month_index = r.janfeb ? d.mp - 4'd10 : d.mp + 4'd2;
                r.ylo = d.yoe + 9'(r.janfeb);
                r.year = 12'(12'(d.era) * 12'd400) + 12'(r.ylo);
            end
            12:
            begin
                leap = (d.ylo[1:0] == 2'd0) && (d.ylo != 9'd100)
                       && (d.ylo != 9'd200) && (d.ylo != 9'd300);
                r.day_of_year = d.janfeb ? d.doy - 9'd306
                                         : d.doy + 9'd59 + 9'(leap);
                r.years_since_1900 = 9'(d.year - 12'd1900);
                oor = (14'(d.year) < first_year) || (14'(d.year) > last_year);
                r.out_of_range = oor;
                if (oor)
                begin
                    r.second = '0;
                    r.minute = '0;
                    r.hour = '0;
                    r.day_of_month = '0;
                    r.month_index = '0;
                    r.years_since_1900 = '0;
                    r.weekday = '0;
                    r.day_of_year = '0;
                end
            end
            default:
            begin
                r = d;
            end
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/ecal_if.sv -----
interface ecal_in_if;
    logic        valid;
    logic        ready;
    logic [34:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface ecal_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day_of_month;
    logic [3:0] month_index;
    logic [8:0] years_since_1900;
    logic [2:0] weekday;
    logic [8:0] day_of_year;
    logic       out_of_range;

    modport source (output valid, output second, output minute, output hour,
                    output day_of_month, output month_index, output years_since_1900,
                    output weekday, output day_of_year, output out_of_range,
                    input ready);
    modport sink (input valid, input second, input minute, input hour,
                  input day_of_month, input month_index, input years_since_1900,
                  input weekday, input day_of_year, input out_of_range,
                  output ready);
endinterface

// ----- hw/rtl/ecal_stage.sv -----
module ecal_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    input  ecal_pkg::pipe_t   up_data,
    output logic              up_ready,
    output logic              valid,
    output ecal_pkg::pipe_t   data,
    input  logic              down_ready
);

    logic            valid_reg;
    ecal_pkg::pipe_t data_reg;

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= up_data;
        end
    end

    assign valid = valid_reg;
    assign data = data_reg;

endmodule

// ----- hw/rtl/epoch_seconds_to_utc_calendar_core.sv -----
// Converts a signed 35-bit count of seconds since 1970-01-01 00:00:00 UTC into the
// Gregorian UTC date and time in a 13-stage pipeline that accepts one item per cycle
// while cal.ready does not stall the output; the stage count is set by the
// date path, a chain of constant divisions (by 86400, the 400-year era, the 4- and
// 100-year corrections, 365, 100, 153 and 5), each done by reciprocal multiplication
// with its remainder or correction taken in the same or a later stage.
// Years outside FIRST_YEAR..LAST_YEAR set out_of_range and zero every other field.
module epoch_seconds_to_utc_calendar_core #(
    parameter int unsigned FIRST_YEAR = 1900,
    parameter int unsigned LAST_YEAR = 2399
) (
    input logic       clk,
    input logic       rst_n,
    ecal_in_if.sink   stamp,
    ecal_out_if.source cal
);

    localparam int unsigned N = ecal_pkg::NUM_STAGES;

    ecal_pkg::pipe_t in_data;
    ecal_pkg::pipe_t stage_in [N];
    ecal_pkg::pipe_t stage_q [N];
    logic            stage_valid [N];
    logic            stage_ready [N];
    logic            down_ready [N];

    always_comb
    begin
        in_data = '0;
        in_data.secs = stamp.epoch_seconds;
    end

    assign stamp.ready = stage_ready[0];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        if (i == 0)
        begin : g_first
            assign stage_in[i] = ecal_pkg::stage_step(i, in_data, 14'(FIRST_YEAR),
                                                      14'(LAST_YEAR));
        end
        else
        begin : g_rest
            assign stage_in[i] = ecal_pkg::stage_step(i, stage_q[i-1], 14'(FIRST_YEAR),
                                                      14'(LAST_YEAR));
        end
        if (i == N - 1)
        begin : g_last
            assign down_ready[i] = cal.ready;
        end
        else
        begin : g_mid
            assign down_ready[i] = stage_ready[i+1];
        end
        ecal_stage u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   ((i == 0) ? stamp.valid : stage_valid[(i == 0) ? 0 : i-1]),
            .up_data    (stage_in[i]),
            .up_ready   (stage_ready[i]),
            .valid      (stage_valid[i]),
            .data       (stage_q[i]),
            .down_ready (down_ready[i])
        );
    end

    assign cal.valid = stage_valid[N-1];
    assign cal.second = stage_q[N-1].second;
    assign cal.minute = stage_q[N-1].minute;
    assign cal.hour = stage_q[N-1].hour;
    assign cal.day_of_month = stage_q[N-1].day_of_month;
    assign cal.month_index = stage_q[N-1].month_index;
    assign cal.years_since_1900 = stage_q[N-1].years_since_1900;
    assign cal.weekday = stage_q[N-1].weekday;
    assign cal.day_of_year = stage_q[N-1].day_of_year;
    assign cal.out_of_range = stage_q[N-1].out_of_range;

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        stamp.valid && stamp.ready |=> stage_valid[0])
        else $error("accepted item did not enter the pipeline");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cal.valid && cal.out_of_range |-> cal.day_of_month == 5'd0
            && cal.years_since_1900 == 9'd0 && cal.weekday == 3'd0)
        else $error("out-of-range item carries nonzero fields");

    a_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
        cal.valid && !cal.out_of_range |-> cal.day_of_month != 5'd0
            && cal.month_index <= 4'd11 && cal.weekday <= 3'd6
            && cal.day_of_year <= 9'd365)
        else $error("date fields out of range");

    a_time_sane: assert property (@(posedge clk) disable iff (!rst_n)
        cal.valid |-> cal.hour <= 5'd23 && cal.minute <= 6'd59 && cal.second <= 6'd59)
        else $error("time fields out of range");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int FIRST_YEAR = 1900;
    localparam int LAST_YEAR = 2399;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 3 * ecal_pkg::NUM_STAGES;
    localparam int HOLD_CYCLES = 300;
    localparam longint SPAN_LOW = -64'sd2208988800;
    localparam longint SPAN_HIGH = 64'sd13569465599;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day_of_month;
        logic [3:0] month_index;
        logic [8:0] years_since_1900;
        logic [2:0] weekday;
        logic [8:0] day_of_year;
        logic       out_of_range;
    } cal_t;

    typedef struct {
        logic [34:0] secs;
        bit          known;
        cal_t        res;
    } row_t;

    logic clk;
    logic rst_n;

    ecal_in_if stamp ();
    ecal_out_if cal ();

    epoch_seconds_to_utc_calendar_core #(
        .FIRST_YEAR(FIRST_YEAR),
        .LAST_YEAR(LAST_YEAR)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .stamp(stamp),
        .cal(cal)
    );

    cal_t pending_dates[$];
    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int hold_served;
    int hold_left;
    int mismatches;
    int results_seen;
    int out_of_range_seen;
    int cycles;
    int items_sent;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic bit is_leap(longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic cal_t civil_from_secs(logic [34:0] raw);
        longint secs;
        longint days;
        longint rem;
        longint yr;
        longint len;
        longint wd;
        longint yd;
        int m;
        int ml[12];
        cal_t r;
        secs = longint'($signed(raw));
        days = secs / 86400;
        rem = secs % 86400;
        if (rem < 0)
        begin
            rem += 86400;
            days--;
        end
        wd = (days + 4) % 7;
        if (wd < 0)
            wd += 7;
        yr = 1970;
        forever
        begin
            len = is_leap(yr) ? 366 : 365;
            if (days >= len)
            begin
                days -= len;
                yr++;
            end
            else if (days < 0)
            begin
                yr--;
                days += is_leap(yr) ? 366 : 365;
            end
            else
                break;
        end
        r = '0;
        if (yr < FIRST_YEAR || yr > LAST_YEAR)
        begin
            r.out_of_range = 1'b1;
            return r;
        end
        yd = days;
        ml = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (is_leap(yr))
            ml[1] = 29;
        m = 0;
        while (m < 12 && days >= ml[m])
        begin
            days -= ml[m];
            m++;
        end
        r.second = 6'(rem % 60);
        r.minute = 6'((rem % 3600) / 60);
        r.hour = 5'(rem / 3600);
        r.day_of_month = 5'(days + 1);
        r.month_index = 4'(m);
        r.years_since_1900 = 9'(yr - 1900);
        r.weekday = 3'(wd);
        r.day_of_year = 9'(yd);
        return r;
    endfunction

    function automatic logic [34:0] random_stamp();
        int k;
        longint v;
        longint d;
        k = $urandom_range(99);
        if (k < 70)
        begin
            v = longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF);
            v = SPAN_LOW + v % (SPAN_HIGH - SPAN_LOW + 1);
        end
        else if (k < 85)
        begin
            d = longint'($urandom_range(182621)) - 25568;
            if ($urandom_range(1))
                v = d * 86400 + $urandom_range(2);
            else
                v = d * 86400 + 86399 - $urandom_range(2);
        end
        else
            v = longint'({$urandom, $urandom});
        return v[34:0];
    endfunction

    task automatic offer(logic [34:0] secs, bit known, cal_t res);
        bit take;
        while ($urandom_range(99) < send_idle_pct)
        begin
            stamp.valid <= 1'b0;
            @(posedge clk);
        end
        stamp.valid <= 1'b1;
        stamp.epoch_seconds <= secs;
        take = 1'b0;
        while (!take)
        begin
            @(negedge clk);
            take = stamp.ready;
            @(posedge clk);
        end
        pending_dates.push_back(known ? res : civil_from_secs(secs));
        items_sent++;
    endtask

    task automatic random_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            offer(random_stamp(), 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            cal.ready <= 1'b0;
        else if (hold_requests != hold_served)
        begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            cal.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            cal.ready <= 1'b0;
        end
        else
            cal.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(negedge clk)
    begin
        cal_t got;
        cal_t want;
        if (rst_n && cal.valid && cal.ready)
        begin
            got.second = cal.second;
            got.minute = cal.minute;
            got.hour = cal.hour;
            got.day_of_month = cal.day_of_month;
            got.month_index = cal.month_index;
            got.years_since_1900 = cal.years_since_1900;
            got.weekday = cal.weekday;
            got.day_of_year = cal.day_of_year;
            got.out_of_range = cal.out_of_range;
            results_seen++;
            if (got.out_of_range)
                out_of_range_seen++;
            if (pending_dates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result item at cycle %0d", cycles);
            end
            else
            begin
                want = pending_dates.pop_front();
                if (got.second !== want.second || got.minute !== want.minute
                    || got.hour !== want.hour || got.day_of_month !== want.day_of_month
                    || got.month_index !== want.month_index
                    || got.years_since_1900 !== want.years_since_1900
                    || got.weekday !== want.weekday
                    || got.day_of_year !== want.day_of_year
                    || got.out_of_range !== want.out_of_range)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch at result %0d: expected %p, got %p",
                                 results_seen, want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        row_t rows[$];
        row_t row;
        cal_t none;
        cycles = 0;
        mismatches = 0;
        results_seen = 0;
        out_of_range_seen = 0;
        items_sent = 0;
        hold_requests = 0;
        hold_served = 0;
        hold_left = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        stamp.valid = 1'b0;
        stamp.epoch_seconds = '0;
        cal.ready = 1'b0;
        none = '0;

        rows.push_back('{35'd0, 1'b1, '{6'd0, 6'd0, 5'd0, 5'd1, 4'd0, 9'd70, 3'd4,
                                        9'd0, 1'b0}});
        rows.push_back('{35'(-64'sd2208988800), 1'b1,
                         '{6'd0, 6'd0, 5'd0, 5'd1, 4'd0, 9'd0, 3'd1, 9'd0, 1'b0}});
        rows.push_back('{35'(-64'sd2208988801), 1'b1,
                         '{6'd0, 6'd0, 5'd0, 5'd0, 4'd0, 9'd0, 3'd0, 9'd0, 1'b1}});
        rows.push_back('{35'(64'sd13569465600), 1'b1,
                         '{6'd0, 6'd0, 5'd0, 5'd0, 4'd0, 9'd0, 3'd0, 9'd0, 1'b1}});
        rows.push_back('{35'h4_0000_0000, 1'b1,
                         '{6'd0, 6'd0, 5'd0, 5'd0, 4'd0, 9'd0, 3'd0, 9'd0, 1'b1}});
        rows.push_back('{35'h3_FFFF_FFFF, 1'b1,
                         '{6'd0, 6'd0, 5'd0, 5'd0, 4'd0, 9'd0, 3'd0, 9'd0, 1'b1}});
        rows.push_back('{35'(64'sd13569465599), 1'b0, none});
        rows.push_back('{35'h7_FFFF_FFFF, 1'b0, none});
        rows.push_back('{35'd86399, 1'b0, none});
        rows.push_back('{35'd86400, 1'b0, none});
        rows.push_back('{35'(-64'sd86400), 1'b0, none});
        rows.push_back('{35'(-64'sd86401), 1'b0, none});
        rows.push_back('{35'd951782400, 1'b0, none});
        rows.push_back('{35'd951868800, 1'b0, none});
        rows.push_back('{35'(-64'sd2203891200), 1'b0, none});
        rows.push_back('{35'(-64'sd2203891201), 1'b0, none});
        rows.push_back('{35'd2147483647, 1'b0, none});
        rows.push_back('{35'd2147483648, 1'b0, none});
        rows.push_back('{35'd4107542399, 1'b0, none});
        rows.push_back('{35'd4107542400, 1'b0, none});
        rows.push_back('{35'd946684799, 1'b0, none});
        rows.push_back('{35'd978307199, 1'b0, none});
        rows.push_back('{35'd10413791999, 1'b0, none});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            row = rows[i];
            offer(row.secs, row.known, row.res);
        end

        random_phase(0, 0, 230);
        random_phase(59, 0, 230);
        random_phase(0, 59, 230);
        random_phase(34, 34, 230);
        hold_requests = hold_requests + 1;
        random_phase(0, 20, 230);
        stamp.valid <= 1'b0;

        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d timestamps and checked %0d calendar results, %0d out of range.",
                 items_sent, results_seen, out_of_range_seen);
        $display("Phases ran with no idling, sender gaps, receiver stalls, both, and a long hold.");
        if (mismatches == 0 && pending_dates.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/ecal_pkg.sv
hw/rtl/ecal_if.sv
hw/rtl/ecal_stage.sv
hw/rtl/epoch_seconds_to_utc_calendar_core.sv
verif/testbench.sv
